// File: src/ted_pkg.sv
`timescale 1ns / 1ps

package ted_pkg;

  // Field widths of the packet and result beats.
  localparam int DUR_W   = 16;
  localparam int TS_W    = 32;
  localparam int LEN_W   = 11;
  localparam int CODE_W  = 8;
  localparam int KEY_W   = 4;
  localparam int VOL_W   = 6;
  localparam int STAT_W  = 2;

  // Configuration register widths and port widths.
  localparam int UNIT_W  = 10;
  localparam int MAXD_W  = 16;
  localparam int RATE_W  = 16;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  // Derived tick values: step of up to 1023 * 65535 / 1000, limit of up to
  // 65535 * 65535 / 1000.
  localparam int PRODS_W = UNIT_W + RATE_W;
  localparam int PRODL_W = MAXD_W + RATE_W;
  localparam int STEP_W  = 17;
  localparam int LIM_W   = 23;
  localparam int RMUL_W  = 64;

  // Division by 1000 as a multiplication by ceil(2^41 / 1000) and a shift.
  // Exact for every dividend below 2^32.
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;

  // Remainder unit: one dividend bit per cycle.
  localparam int CNT_W = $clog2(DUR_W);

  // Packet rules and limits.
  localparam logic [LEN_W-1:0]  EVENT_PAYLOAD_BYTES = LEN_W'(4);
  localparam logic [CODE_W-1:0] KEY_MAX     = CODE_W'(15);
  localparam logic [DUR_W-1:0]  DUR_MAX     = {DUR_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(8000);

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_EMIT    = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_IGNORED = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_BAD     = STAT_W'(2);

  // Configuration register indices.
  localparam logic [CIDX_W-1:0] CFG_UNIT_TIME = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_MAX_DUR   = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] CFG_CLK_RATE  = CIDX_W'(2);

  // One classified packet as it waits between the front and the back.
  typedef struct packed {
    logic              bad;
    logic              marker;
    logic [TS_W-1:0]   ts;
    logic [KEY_W-1:0]  key;
    logic [VOL_W-1:0]  vol;
    logic [DUR_W-1:0]  dur;
  } q_entry_t;

  // Tick values derived from the configuration registers.
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [DUR_W-1:0]  lim;
    logic              lim_en;
  } derived_t;

endpackage

// File: src/ted_cfg.sv
`timescale 1ns / 1ps

module ted_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ted_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [ted_pkg::CDATA_W-1:0]   cfg_data,
  output logic                          busy,
  output ted_pkg::derived_t             derived
);

  logic [ted_pkg::UNIT_W-1:0]  unit_r;
  logic [ted_pkg::MAXD_W-1:0]  max_r;
  logic [ted_pkg::RATE_W-1:0]  rate_r;
  logic [1:0]                  busy_cnt_r;
  logic [ted_pkg::PRODS_W-1:0] prod_step_r;
  logic [ted_pkg::PRODL_W-1:0] prod_lim_r;
  logic [ted_pkg::RMUL_W-1:0]  step_full;
  logic [ted_pkg::RMUL_W-1:0]  lim_full;
  logic [ted_pkg::STEP_W-1:0]  step_q;
  logic [ted_pkg::LIM_W-1:0]   lim_q;
  ted_pkg::derived_t           derived_r;
  ted_pkg::derived_t           derived_nxt;

  // Always accepts; the user must write only while idle, unenforced.
  assign cfg_ready = 1'b1;

  // Registers, and a countdown that covers the two-stage recompute.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r     <= '0;
      max_r      <= '0;
      rate_r     <= ted_pkg::RATE_RESET;
      busy_cnt_r <= 2'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        ted_pkg::CFG_UNIT_TIME: unit_r <= cfg_data[ted_pkg::UNIT_W-1:0];
        ted_pkg::CFG_MAX_DUR:   max_r  <= cfg_data[ted_pkg::MAXD_W-1:0];
        ted_pkg::CFG_CLK_RATE:  rate_r <= cfg_data[ted_pkg::RATE_W-1:0];
        default: ;
      endcase
      busy_cnt_r <= 2'd2;
    end else if (busy_cnt_r != 2'd0) begin
      busy_cnt_r <= busy_cnt_r - 2'd1;
    end
  end

  assign busy = (busy_cnt_r != 2'd0);

  // First stage: milliseconds times the clock rate.
  always_ff @(posedge clk) begin
    prod_step_r <= ted_pkg::PRODS_W'(unit_r) * ted_pkg::PRODS_W'(rate_r);
    prod_lim_r  <= ted_pkg::PRODL_W'(max_r) * ted_pkg::PRODL_W'(rate_r);
  end

  // Second stage: divide both products by 1000 through the reciprocal.
  always_comb begin
    step_full = ted_pkg::RMUL_W'(prod_step_r) * ted_pkg::RMUL_W'(ted_pkg::RECIP_1000);
    lim_full  = ted_pkg::RMUL_W'(prod_lim_r) * ted_pkg::RMUL_W'(ted_pkg::RECIP_1000);
    step_q    = step_full[ted_pkg::RECIP_SHIFT +: ted_pkg::STEP_W];
    lim_q     = lim_full[ted_pkg::RECIP_SHIFT +: ted_pkg::LIM_W];
    derived_nxt.step   = step_q;
    derived_nxt.lim    = lim_q[ted_pkg::DUR_W-1:0];
    derived_nxt.lim_en = (max_r != '0) &&
                         (lim_q < ted_pkg::LIM_W'(ted_pkg::DUR_MAX));
  end

  always_ff @(posedge clk) begin
    derived_r <= derived_nxt;
  end

  assign derived = derived_r;

endmodule

// File: src/ted_front.sv
`timescale 1ns / 1ps

module ted_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_packet_ok,
  input  logic [ted_pkg::LEN_W-1:0]     in_payload_bytes,
  input  logic                          in_marker_bit,
  input  logic [ted_pkg::TS_W-1:0]      in_rtp_timestamp,
  input  logic [ted_pkg::CODE_W-1:0]    in_event_code,
  input  logic [ted_pkg::VOL_W-1:0]     in_event_volume,
  input  logic [ted_pkg::DUR_W-1:0]     in_event_duration,
  input  logic                          cfg_busy,
  input  logic                          pop,
  output logic                          q_valid,
  output ted_pkg::q_entry_t             q_head
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  ted_pkg::q_entry_t      mem_r [QDEPTH];
  ted_pkg::q_entry_t      entry;
  logic [QPTR_W-1:0]      wr_ptr_r;
  logic [QPTR_W-1:0]      rd_ptr_r;
  logic [QCNT_W-1:0]      cnt_r;
  logic                   push;
  logic                   do_pop;

  // Classify the beat: malformed, wrong length or unknown event is bad.
  always_comb begin
    entry.bad    = !in_packet_ok ||
                   (in_payload_bytes != ted_pkg::EVENT_PAYLOAD_BYTES) ||
                   (in_event_code > ted_pkg::KEY_MAX);
    entry.marker = in_marker_bit;
    entry.ts     = in_rtp_timestamp;
    entry.key    = in_event_code[ted_pkg::KEY_W-1:0];
    entry.vol    = in_event_volume;
    entry.dur    = in_event_duration;
  end

  // Hold off while the queue is full or derived settings are settling.
  assign in_stall = cfg_busy || (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && q_valid;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = mem_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// File: src/ted_div.sv
`timescale 1ns / 1ps

module ted_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ted_pkg::DUR_W-1:0]   dividend,
  input  logic [ted_pkg::STEP_W-1:0]  divisor,
  output logic                        done,
  output logic [ted_pkg::DUR_W-1:0]   rem
);

  logic                        run_r;
  logic                        done_r;
  logic [ted_pkg::CNT_W-1:0]   cnt_r;
  logic [ted_pkg::STEP_W-1:0]  rem_r;
  logic [ted_pkg::STEP_W-1:0]  dsr_r;
  logic [ted_pkg::DUR_W-1:0]   dq_r;
  logic [ted_pkg::STEP_W:0]    trial;
  logic [ted_pkg::STEP_W-1:0]  rem_nxt;

  // Restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_r, dq_r[ted_pkg::DUR_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = ted_pkg::STEP_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[ted_pkg::STEP_W-1:0];
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + ted_pkg::CNT_W'(1);
        if (cnt_r == ted_pkg::CNT_W'(ted_pkg::DUR_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[ted_pkg::DUR_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  // The remainder never exceeds the 16-bit dividend.
  assign rem  = rem_r[ted_pkg::DUR_W-1:0];

endmodule

// File: src/ted_back.sv
`timescale 1ns / 1ps

module ted_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ted_pkg::q_entry_t             q_head,
  output logic                          pop,
  input  ted_pkg::derived_t             derived,
  output logic                          div_start,
  input  logic                          div_done,
  input  logic [ted_pkg::DUR_W-1:0]     div_rem,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ted_pkg::STAT_W-1:0]    out_status,
  output logic                          out_event_started,
  output logic [ted_pkg::KEY_W-1:0]     out_key_number,
  output logic [ted_pkg::VOL_W-1:0]     out_key_volume,
  output logic [ted_pkg::DUR_W-1:0]     out_segment_samples,
  output logic [ted_pkg::DUR_W-1:0]     out_segment_start,
  output logic [ted_pkg::DUR_W-1:0]     out_segment_end
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROUND,
    S_CLAMP,
    S_DONE
  } state_t;

  state_t                        state_r;
  ted_pkg::q_entry_t             ent_r;
  logic [ted_pkg::DUR_W-1:0]     dur_r;
  logic [ted_pkg::DUR_W-1:0]     rem_r;
  logic [ted_pkg::TS_W-1:0]      last_ts_r;
  logic [ted_pkg::DUR_W-1:0]     furthest_r;
  logic                          out_valid_r;
  logic [ted_pkg::STAT_W-1:0]    status_r;
  logic                          started_r;
  logic [ted_pkg::KEY_W-1:0]     key_r;
  logic [ted_pkg::VOL_W-1:0]     vol_r;
  logic [ted_pkg::DUR_W-1:0]     samples_r;
  logic [ted_pkg::DUR_W-1:0]     seg_start_r;
  logic [ted_pkg::DUR_W-1:0]     seg_end_r;

  logic [ted_pkg::STEP_W:0]      up_sum;
  logic [ted_pkg::DUR_W-1:0]     rounded;
  logic [ted_pkg::DUR_W-1:0]     clamped;
  logic                          new_ev;
  logic [ted_pkg::DUR_W-1:0]     seg;
  logic [ted_pkg::DUR_W-1:0]     seg_start;
  logic                          out_free;

  assign pop       = (state_r == S_IDLE) && q_valid;
  assign div_start = pop && !q_head.bad && (derived.step != '0);
  assign out_free  = !out_valid_r || !out_stall;

  // Round up to a whole step, or down when rounding up nears the ceiling.
  always_comb begin
    up_sum = (ted_pkg::STEP_W + 1)'(dur_r) + (ted_pkg::STEP_W + 1)'(derived.step);
    if (rem_r == '0) begin
      rounded = dur_r;
    end else if (up_sum < (ted_pkg::STEP_W + 1)'(ted_pkg::DUR_MAX)) begin
      rounded = ted_pkg::DUR_W'(up_sum - (ted_pkg::STEP_W + 1)'(rem_r));
    end else begin
      rounded = dur_r - rem_r;
    end
  end

  // Clamp to the maximum duration where one is in force.
  always_comb begin
    if (derived.lim_en && (dur_r > derived.lim)) begin
      clamped = derived.lim;
    end else begin
      clamped = dur_r;
    end
  end

  // New event on the marker or a changed timestamp; otherwise only growth.
  always_comb begin
    new_ev = ent_r.marker || (ent_r.ts != last_ts_r);
    if (new_ev) begin
      seg       = dur_r;
      seg_start = '0;
    end else if (dur_r > furthest_r) begin
      seg       = dur_r - furthest_r;
      seg_start = furthest_r;
    end else begin
      seg       = '0;
      seg_start = '0;
    end
  end

  // Sequencer, event state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_ts_r   <= '0;
      furthest_r  <= '0;
    end else begin
      // A taken beat is cleared unless a new one is loaded in its place.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ent_r <= q_head;
            dur_r <= q_head.dur;
            rem_r <= '0;
            if (q_head.bad) begin
              state_r <= S_DONE;
            end else if (derived.step != '0) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_CLAMP;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            rem_r   <= div_rem;
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          dur_r   <= rounded;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          dur_r   <= clamped;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (ent_r.bad) begin
              status_r    <= ted_pkg::ST_BAD;
              started_r   <= 1'b0;
              key_r       <= '0;
              vol_r       <= '0;
              samples_r   <= '0;
              seg_start_r <= '0;
              seg_end_r   <= '0;
            end else begin
              started_r <= new_ev;
              key_r     <= ent_r.key;
              vol_r     <= ent_r.vol;
              if (new_ev) begin
                last_ts_r  <= ent_r.ts;
                furthest_r <= dur_r;
              end else if (dur_r > furthest_r) begin
                furthest_r <= dur_r;
              end
              if (seg != '0) begin
                status_r    <= ted_pkg::ST_EMIT;
                samples_r   <= seg;
                seg_start_r <= seg_start;
                seg_end_r   <= dur_r;
              end else begin
                status_r    <= ted_pkg::ST_IGNORED;
                samples_r   <= '0;
                seg_start_r <= '0;
                seg_end_r   <= '0;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_event_started   = started_r;
  assign out_key_number      = key_r;
  assign out_key_volume      = vol_r;
  assign out_segment_samples = samples_r;
  assign out_segment_start   = seg_start_r;
  assign out_segment_end     = seg_end_r;

endmodule

// File: src/telephone_event_depacketizer_top.sv
`timescale 1ns / 1ps

// Telephone-event depacketizer: turns parsed telephone-event packets into
// tone segments, one result beat for every packet beat.
// The input channel carries one packet per beat (in_valid / in_stall); the
// front classifies it and parks it in a two-entry queue. The back rounds and
// clamps the duration, tracks the current event and writes one result beat
// to the output register (out_valid / out_stall).
// A good packet passes through the back in order: fetch, wait on the
// 16-step bit-serial remainder against the unit step, round, clamp and
// retire. Without a unit step the remainder and the rounding are skipped,
// and a bad packet goes from fetch straight to retire. The back finishes
// one packet before it fetches the next; the queue can take more meanwhile.
// Writes to the configuration port are taken at once; the block then holds
// in_stall while the tick values derived from the registers settle. Reset
// restores the register defaults, clears the event state and empties the
// queue; in_stall stays high after it until the derived values settle.
// When the receiver stalls, the result waits in the output register, the
// back finishes its packet and waits, and the queue fills, then in_stall rises.
module telephone_event_depacketizer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_packet_ok,
  input  logic [ted_pkg::LEN_W-1:0]     in_payload_bytes,
  input  logic                          in_marker_bit,
  input  logic [ted_pkg::TS_W-1:0]      in_rtp_timestamp,
  input  logic [ted_pkg::CODE_W-1:0]    in_event_code,
  input  logic [ted_pkg::VOL_W-1:0]     in_event_volume,
  input  logic [ted_pkg::DUR_W-1:0]     in_event_duration,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ted_pkg::STAT_W-1:0]    out_status,
  output logic                          out_event_started,
  output logic [ted_pkg::KEY_W-1:0]     out_key_number,
  output logic [ted_pkg::VOL_W-1:0]     out_key_volume,
  output logic [ted_pkg::DUR_W-1:0]     out_segment_samples,
  output logic [ted_pkg::DUR_W-1:0]     out_segment_start,
  output logic [ted_pkg::DUR_W-1:0]     out_segment_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ted_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [ted_pkg::CDATA_W-1:0]   cfg_data
);

  logic                        cfg_busy;
  ted_pkg::derived_t           derived;
  logic                        pop;
  logic                        q_valid;
  ted_pkg::q_entry_t           q_head;
  logic                        div_start;
  logic                        div_done;
  logic [ted_pkg::DUR_W-1:0]   div_rem;

  // Configuration registers and derived tick values.
  ted_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (cfg_busy),
    .derived   (derived)
  );

  // Packet intake, classification and queue.
  ted_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_packet_ok      (in_packet_ok),
    .in_payload_bytes  (in_payload_bytes),
    .in_marker_bit     (in_marker_bit),
    .in_rtp_timestamp  (in_rtp_timestamp),
    .in_event_code     (in_event_code),
    .in_event_volume   (in_event_volume),
    .in_event_duration (in_event_duration),
    .cfg_busy          (cfg_busy),
    .pop               (pop),
    .q_valid           (q_valid),
    .q_head            (q_head)
  );

  // Remainder of the duration by the unit step.
  ted_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_head.dur),
    .divisor  (derived.step),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Duration shaping, event tracking and result register.
  ted_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .pop                 (pop),
    .derived             (derived),
    .div_start           (div_start),
    .div_done            (div_done),
    .div_rem             (div_rem),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_event_started   (out_event_started),
    .out_key_number      (out_key_number),
    .out_key_volume      (out_key_volume),
    .out_segment_samples (out_segment_samples),
    .out_segment_start   (out_segment_start),
    .out_segment_end     (out_segment_end)
  );

endmodule

// File: src/ted_chk.sv
`timescale 1ns / 1ps

module ted_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_packet_ok,
  input  logic [ted_pkg::LEN_W-1:0]     in_payload_bytes,
  input  logic                          in_marker_bit,
  input  logic [ted_pkg::TS_W-1:0]      in_rtp_timestamp,
  input  logic [ted_pkg::CODE_W-1:0]    in_event_code,
  input  logic [ted_pkg::VOL_W-1:0]     in_event_volume,
  input  logic [ted_pkg::DUR_W-1:0]     in_event_duration,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ted_pkg::STAT_W-1:0]    out_status,
  input  logic                          out_event_started,
  input  logic [ted_pkg::KEY_W-1:0]     out_key_number,
  input  logic [ted_pkg::VOL_W-1:0]     out_key_volume,
  input  logic [ted_pkg::DUR_W-1:0]     out_segment_samples,
  input  logic [ted_pkg::DUR_W-1:0]     out_segment_start,
  input  logic [ted_pkg::DUR_W-1:0]     out_segment_end,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ted_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [ted_pkg::CDATA_W-1:0]   cfg_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A result beat carries one of the three status codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ted_pkg::ST_EMIT ||
                   out_status == ted_pkg::ST_IGNORED ||
                   out_status == ted_pkg::ST_BAD))
    else $error("result beat with unknown status");

  // A bad packet reports nothing but its status.
  a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ted_pkg::ST_BAD |->
      !out_event_started && out_key_number == '0 && out_key_volume == '0 &&
      out_segment_samples == '0 && out_segment_start == '0 &&
      out_segment_end == '0)
    else $error("bad packet result carries data");

  // An emitted segment is non-empty and spans exactly its sample count.
  a_emit_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ted_pkg::ST_EMIT |->
      out_segment_samples != '0 &&
      (out_segment_end - out_segment_start) == out_segment_samples &&
      out_segment_end >= out_segment_start)
    else $error("emitted segment span inconsistent");

  // An ignored packet carries an empty segment.
  a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ted_pkg::ST_IGNORED |->
      out_segment_samples == '0 && out_segment_start == '0 &&
      out_segment_end == '0)
    else $error("ignored packet result carries a segment");

endmodule

bind telephone_event_depacketizer_top ted_chk u_ted_chk (.*);

// File: verif/ted_checker.sv
`timescale 1ns / 1ps

module ted_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_packet_ok,
  input  logic [ted_pkg::LEN_W-1:0]     in_payload_bytes,
  input  logic                          in_marker_bit,
  input  logic [ted_pkg::TS_W-1:0]      in_rtp_timestamp,
  input  logic [ted_pkg::CODE_W-1:0]    in_event_code,
  input  logic [ted_pkg::VOL_W-1:0]     in_event_volume,
  input  logic [ted_pkg::DUR_W-1:0]     in_event_duration,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ted_pkg::STAT_W-1:0]    out_status,
  input  logic                          out_event_started,
  input  logic [ted_pkg::KEY_W-1:0]     out_key_number,
  input  logic [ted_pkg::VOL_W-1:0]     out_key_volume,
  input  logic [ted_pkg::DUR_W-1:0]     out_segment_samples,
  input  logic [ted_pkg::DUR_W-1:0]     out_segment_start,
  input  logic [ted_pkg::DUR_W-1:0]     out_segment_end,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ted_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [ted_pkg::CDATA_W-1:0]   cfg_data,
  input  logic                          end_check,
  output int                            segments_seen,
  output int                            failures
);

  localparam logic [31:0] MS_PER_SECOND = 32'd1000;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic                       ok;
    logic [ted_pkg::LEN_W-1:0]  len;
    logic                       marker;
    logic [ted_pkg::TS_W-1:0]   ts;
    logic [ted_pkg::CODE_W-1:0] code;
    logic [ted_pkg::VOL_W-1:0]  vol;
    logic [ted_pkg::DUR_W-1:0]  dur;
  } packet_t;

  typedef struct packed {
    logic [ted_pkg::STAT_W-1:0] status;
    logic                       started;
    logic [ted_pkg::KEY_W-1:0]  key;
    logic [ted_pkg::VOL_W-1:0]  vol;
    logic [ted_pkg::DUR_W-1:0]  samples;
    logic [ted_pkg::DUR_W-1:0]  seg_start;
    logic [ted_pkg::DUR_W-1:0]  seg_end;
  } segment_t;

  // Our own copy of the registers and of the event tracking state.
  logic [ted_pkg::UNIT_W-1:0] unit_ms;
  logic [ted_pkg::MAXD_W-1:0] limit_ms;
  logic [ted_pkg::RATE_W-1:0] rate_hz;
  logic [ted_pkg::TS_W-1:0]   event_ts;
  logic [ted_pkg::DUR_W-1:0]  peak_dur;

  segment_t pending_segments[$];
  int       mismatches;
  bit       leftovers_done;

  // Round the duration to whole unit steps, then clamp it to the maximum.
  function automatic logic [ted_pkg::DUR_W-1:0] shape_duration(
      logic [ted_pkg::DUR_W-1:0] raw);
    logic [31:0] d;
    logic [31:0] step;
    logic [31:0] rem;
    logic [31:0] lim;
    d = 32'(raw);
    if (unit_ms != '0) begin
      step = (32'(unit_ms) * 32'(rate_hz)) / MS_PER_SECOND;
      if (step != 0) begin
        rem = d % step;
        if (rem != 0) begin
          // Round up only while well clear of the 16-bit ceiling.
          if (d + step < 32'(ted_pkg::DUR_MAX)) begin
            d = d + (step - rem);
          end else begin
            d = d - rem;
          end
        end
      end
    end
    if (limit_ms != '0) begin
      lim = (32'(limit_ms) * 32'(rate_hz)) / MS_PER_SECOND;
      if (lim < 32'(ted_pkg::DUR_MAX) && d > lim) begin
        d = lim;
      end
    end
    return d[ted_pkg::DUR_W-1:0];
  endfunction

  // Work out the result beat of one packet and advance the event state.
  function automatic segment_t predict_segment(packet_t p);
    segment_t                  r;
    logic [ted_pkg::DUR_W-1:0] d;
    logic [ted_pkg::DUR_W-1:0] seg;
    r = '0;
    if (!p.ok || p.len != ted_pkg::EVENT_PAYLOAD_BYTES || p.code > ted_pkg::KEY_MAX) begin
      r.status = ted_pkg::ST_BAD;
      return r;
    end
    d   = shape_duration(p.dur);
    seg = '0;
    if (p.marker || p.ts != event_ts) begin
      r.started = 1'b1;
      event_ts  = p.ts;
      peak_dur  = d;
      seg       = d;
    end else if (d > peak_dur) begin
      // Only the part beyond the furthest duration so far is new; late
      // packets fall through with nothing to play.
      seg      = d - peak_dur;
      peak_dur = d;
    end
    r.key = p.code[ted_pkg::KEY_W-1:0];
    r.vol = p.vol;
    if (seg != '0) begin
      r.status    = ted_pkg::ST_EMIT;
      r.samples   = seg;
      r.seg_start = peak_dur - seg;
      r.seg_end   = peak_dur;
    end else begin
      r.status = ted_pkg::ST_IGNORED;
    end
    return r;
  endfunction

  function automatic string describe(segment_t s);
    return $sformatf("status=%0d started=%0b key=%0d vol=%0d samples=%0d start=%0d end=%0d",
                     s.status, s.started, s.key, s.vol, s.samples, s.seg_start, s.seg_end);
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Watch the three channels at every edge.
  always @(posedge clk) begin
    packet_t  pkt;
    segment_t got;
    segment_t want;
    if (!rst_n) begin
      unit_ms  = '0;
      limit_ms = '0;
      rate_hz  = ted_pkg::RATE_RESET;
      event_ts = '0;
      peak_dur = '0;
      pending_segments.delete();
      mismatches     = 0;
      leftovers_done = 1'b0;
      segments_seen <= 0;
      failures      <= 0;
    end else begin
      // Register writes; an unknown index is dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ted_pkg::CFG_UNIT_TIME: unit_ms  = cfg_data[ted_pkg::UNIT_W-1:0];
          ted_pkg::CFG_MAX_DUR:   limit_ms = cfg_data[ted_pkg::MAXD_W-1:0];
          ted_pkg::CFG_CLK_RATE:  rate_hz  = cfg_data[ted_pkg::RATE_W-1:0];
          default: ;
        endcase
      end

      // Every accepted packet beat owes exactly one result beat.
      if (in_valid && !in_stall) begin
        pkt.ok     = in_packet_ok;
        pkt.len    = in_payload_bytes;
        pkt.marker = in_marker_bit;
        pkt.ts     = in_rtp_timestamp;
        pkt.code   = in_event_code;
        pkt.vol    = in_event_volume;
        pkt.dur    = in_event_duration;
        pending_segments.push_back(predict_segment(pkt));
      end

      // Compare each result beat with the oldest prediction.
      if (out_valid && !out_stall) begin
        got.status    = out_status;
        got.started   = out_event_started;
        got.key       = out_key_number;
        got.vol       = out_key_volume;
        got.samples   = out_segment_samples;
        got.seg_start = out_segment_start;
        got.seg_end   = out_segment_end;
        segments_seen <= segments_seen + 1;
        if (pending_segments.size() == 0) begin
          note_mismatch({"unexpected result beat: ", describe(got)});
        end else begin
          want = pending_segments.pop_front();
          if (got !== want) begin
            note_mismatch({"result mismatch\n  expected ", describe(want),
                           "\n  actual   ", describe(got)});
          end
        end
      end

      // Anything still waiting at the end never arrived.
      if (end_check && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (pending_segments.size() != 0) begin
          note_mismatch($sformatf("%0d result beats never arrived",
                                  pending_segments.size()));
          mismatches += pending_segments.size() - 1;
        end
      end
      failures <= mismatches;
    end
  end

endmodule

// File: verif/telephone_event_depacketizer_top_tb.sv
`timescale 1ns / 1ps

module telephone_event_depacketizer_top_tb;

  localparam int          RESET_CYCLES = 7;
  localparam int          HOLD_CYCLES  = 250;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_ITEMS  = 100;
  localparam longint      TIMEOUT_NS   = 4_000_000;
  localparam logic [ted_pkg::CIDX_W-1:0] CFG_UNUSED = ted_pkg::CIDX_W'(3);

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_packet_ok = 1'b0;
  logic [ted_pkg::LEN_W-1:0]    in_payload_bytes = '0;
  logic                         in_marker_bit = 1'b0;
  logic [ted_pkg::TS_W-1:0]     in_rtp_timestamp = '0;
  logic [ted_pkg::CODE_W-1:0]   in_event_code = '0;
  logic [ted_pkg::VOL_W-1:0]    in_event_volume = '0;
  logic [ted_pkg::DUR_W-1:0]    in_event_duration = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ted_pkg::STAT_W-1:0]   out_status;
  logic                         out_event_started;
  logic [ted_pkg::KEY_W-1:0]    out_key_number;
  logic [ted_pkg::VOL_W-1:0]    out_key_volume;
  logic [ted_pkg::DUR_W-1:0]    out_segment_samples;
  logic [ted_pkg::DUR_W-1:0]    out_segment_start;
  logic [ted_pkg::DUR_W-1:0]    out_segment_end;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ted_pkg::CIDX_W-1:0]   cfg_index = '0;
  logic [ted_pkg::CDATA_W-1:0]  cfg_data = '0;
  logic                         end_check = 1'b0;
  int                           segments_seen;
  int                           failures;

  int packets_sent  = 0;
  bit idle_on       = 1'b1;
  bit quiet         = 1'b0;
  bit hold_off_req  = 1'b0;

  telephone_event_depacketizer_top i_dut (.*);

  ted_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one packet beat and hold it until it is taken, then perhaps idle.
  task automatic send_pkt(input logic ok, input logic [ted_pkg::LEN_W-1:0] len,
                          input logic marker, input logic [ted_pkg::TS_W-1:0] ts,
                          input logic [ted_pkg::CODE_W-1:0] code,
                          input logic [ted_pkg::VOL_W-1:0] vol,
                          input logic [ted_pkg::DUR_W-1:0] dur);
    in_valid          <= 1'b1;
    in_packet_ok      <= ok;
    in_payload_bytes  <= len;
    in_marker_bit     <= marker;
    in_rtp_timestamp  <= ts;
    in_event_code     <= code;
    in_event_volume   <= vol;
    in_event_duration <= dur;
    do @(posedge clk); while (in_stall);
    packets_sent++;
    if (packets_sent % 30 == 0) begin
      idle_on = ($urandom_range(0, 9) < 7);
    end
    if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every packet has its result.
  task automatic settle();
    in_valid <= 1'b0;
    while (segments_seen < packets_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ted_pkg::CIDX_W-1:0] idx,
                           input logic [ted_pkg::CDATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program all three registers; optionally also poke the unused index.
  task automatic configure(input logic [ted_pkg::UNIT_W-1:0] unit,
                           input logic [ted_pkg::MAXD_W-1:0] maxd,
                           input logic [ted_pkg::RATE_W-1:0] rate, input bit stray);
    write_reg(ted_pkg::CFG_UNIT_TIME, ted_pkg::CDATA_W'(unit));
    write_reg(ted_pkg::CFG_MAX_DUR, ted_pkg::CDATA_W'(maxd));
    write_reg(ted_pkg::CFG_CLK_RATE, ted_pkg::CDATA_W'(rate));
    if (stray) begin
      write_reg(CFG_UNUSED, ted_pkg::CDATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // One event as a sender would build it, with the odd broken packet mixed in.
  task automatic run_event(input int n_pkts);
    logic [ted_pkg::TS_W-1:0]   ts;
    logic [ted_pkg::CODE_W-1:0] code;
    logic [ted_pkg::VOL_W-1:0]  vol;
    logic [ted_pkg::DUR_W-1:0]  dur;
    logic [ted_pkg::LEN_W-1:0]  bad_len;
    logic [31:0]                next;
    logic                       marker;
    int                         r;
    ts   = $urandom;
    code = ted_pkg::CODE_W'($urandom_range(0, 15));
    vol  = ted_pkg::VOL_W'($urandom_range(0, 63));
    dur  = ted_pkg::DUR_W'($urandom_range(0, 2000));
    for (int i = 0; i < n_pkts; i++) begin
      marker = (i == 0);
      if (i > 0) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          // Retransmission: same duration again.
        end else if (r < 4) begin
          dur = dur - ted_pkg::DUR_W'($urandom_range(0, int'(dur)));
        end else if (r == 4) begin
          dur = ted_pkg::DUR_MAX - ted_pkg::DUR_W'($urandom_range(0, 700));
        end else begin
          next = 32'(dur) + $urandom_range(1, 1500);
          dur  = (next > 32'(ted_pkg::DUR_MAX)) ? ted_pkg::DUR_MAX
                                                : next[ted_pkg::DUR_W-1:0];
        end
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        bad_len = ted_pkg::LEN_W'($urandom);
        if (bad_len == ted_pkg::EVENT_PAYLOAD_BYTES) begin
          bad_len = ~bad_len;
        end
        case ($urandom_range(0, 2))
          0: send_pkt(1'b0, ted_pkg::EVENT_PAYLOAD_BYTES, marker, ts, code, vol, dur);
          1: send_pkt(1'b1, bad_len, marker, ts, code, vol, dur);
          default: send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, marker, ts,
                            ted_pkg::CODE_W'($urandom_range(16, 255)), vol, dur);
        endcase
      end else begin
        if (r == 1) begin
          marker = !marker;
        end else if (r == 2) begin
          ts = ts ^ (32'd1 << $urandom_range(0, 31));
        end
        send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, marker, ts, code, vol, dur);
      end
    end
  endtask

  // Receiver: random stall bursts, free stretches, and one long hold-off.
  initial begin
    int span;
    int r;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        span = HOLD_CYCLES;
      end else if (quiet) begin
        out_stall <= 1'b0;
        span = 1;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 12);
        end else if (r < 8) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 12);
        end else begin
          out_stall <= 1'b0;
          span = $urandom_range(20, 80);
        end
      end
      repeat (span - 1) @(posedge clk);
    end
  end

  initial begin
    int phase_start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Rejected packets, then tracking from the reset timestamp at defaults.
    send_pkt(1'b0, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'h1234, 8'd3, 6'd10, 16'd500);
    send_pkt(1'b1, 11'd3, 1'b1, 32'h1234, 8'd3, 6'd10, 16'd500);
    send_pkt(1'b1, '1, 1'b1, 32'h1234, 8'd3, 6'd10, 16'd500);
    send_pkt(1'b1, '0, 1'b1, 32'h1234, 8'd3, 6'd10, 16'd500);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'h1234, 8'd16, 6'd10, 16'd500);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'h1234, '1, '1, '1);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, '0, '0, '0, '0);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, '0, 8'd15, '1, 16'd100);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, '0, 8'd15, '1, 16'd100);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, '0, 8'd15, '1, 16'd50);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, '0, 8'd15, '1, '1);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, '0, 8'd15, '1, '0);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, '1, 8'd5, 6'd1, 16'd800);

    // Step of 400 ticks: rounding up, and rounding down near the ceiling.
    settle();
    configure(10'd50, 16'd0, 16'd8000, 1'b1);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'd7, 8'd1, 6'd20, 16'd1);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, 32'd7, 8'd1, 6'd20, 16'd400);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, 32'd7, 8'd1, 6'd20, 16'd65134);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'd7, 8'd1, 6'd20, 16'd65135);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, 32'd7, 8'd1, 6'd20, 16'd65300);

    // Clamp to a tiny maximum.
    settle();
    configure(10'd50, 16'd1, 16'd8000, 1'b0);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'd8, 8'd2, 6'd30, 16'd100);

    // Widest settings: a step beyond 16 bits and a limit that never clamps.
    settle();
    configure('1, '1, '1, 1'b0);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'd9, 8'd4, 6'd40, '1);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, 32'd9, 8'd4, 6'd40, 16'd12345);

    // Step that truncates to zero and a nonzero maximum of zero ticks.
    settle();
    configure(10'd1, 16'd1, 16'd1, 1'b0);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'd10, 8'd6, 6'd50, 16'd777);

    // Clock rate of zero.
    settle();
    configure(10'd10, 16'd5, 16'd0, 1'b0);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b1, 32'd11, 8'd7, 6'd60, '1);
    send_pkt(1'b1, ted_pkg::EVENT_PAYLOAD_BYTES, 1'b0, 32'd12, 8'd8, 6'd61, '0);

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: configure(10'd20, 16'd0, 16'd8000, 1'b0);
        1: configure(10'd0, 16'd2000, 16'd8000, 1'b0);
        2: configure(10'd1000, '1, 16'd8000, 1'b0);
        3: configure('1, 16'd1, '1, 1'b0);
        4: configure(ted_pkg::UNIT_W'($urandom_range(1, 1023)), ted_pkg::MAXD_W'($urandom),
                     ted_pkg::RATE_W'($urandom_range(1, 65535)), 1'b1);
        5: configure(ted_pkg::UNIT_W'($urandom_range(0, 50)),
                     ted_pkg::MAXD_W'($urandom_range(0, 4000)),
                     ted_pkg::RATE_W'($urandom_range(1, 48000)), 1'b0);
        6: configure(10'd3, 16'd9000, 16'd1000, 1'b0);
        default: configure(10'd0, 16'd0, ted_pkg::RATE_RESET, 1'b0);
      endcase
      quiet = (phase == 7);
      // Long receiver hold-off while the sender keeps offering.
      if (phase == 2) begin
        hold_off_req = 1'b1;
      end
      phase_start = packets_sent;
      while (packets_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          run_event($urandom_range(2, 12));
        end else begin
          send_pkt(1'($urandom),
                   ($urandom_range(0, 1) == 1) ? ted_pkg::EVENT_PAYLOAD_BYTES
                                               : ted_pkg::LEN_W'($urandom),
                   1'($urandom), $urandom,
                   ($urandom_range(0, 1) == 1) ? ted_pkg::CODE_W'($urandom_range(0, 15))
                                               : ted_pkg::CODE_W'($urandom),
                   ted_pkg::VOL_W'($urandom), ted_pkg::DUR_W'($urandom));
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("telephone_event_depacketizer_top_tb OK");
    end else begin
      $display("telephone_event_depacketizer_top_tb NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("telephone_event_depacketizer_top_tb NOT OK");
    $finish;
  end

endmodule
